[hdl/rau_pkg.sv]
// Package for the rational arithmetic unit: payload types, opcodes, control structs.
`timescale 1ns / 1ps
package rau_pkg;

    localparam int unsigned IN_W  = 16;
    localparam int unsigned NUM_W = 33;
    localparam int unsigned DEN_W = 32;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_SUB    = 3'd1,
        OP_MUL    = 3'd2,
        OP_DIV    = 3'd3,
        OP_REDUCE = 3'd4,
        OP_CMP    = 3'd5
    } op_t;

    localparam logic [1:0] CMP_LT = 2'd0;
    localparam logic [1:0] CMP_EQ = 2'd1;
    localparam logic [1:0] CMP_GT = 2'd2;

    typedef struct packed {
        logic [2:0]           req_type;
        logic signed [IN_W-1:0] a_num;
        logic signed [IN_W-1:0] a_den;
        logic signed [IN_W-1:0] b_num;
        logic signed [IN_W-1:0] b_den;
    } req_t;

    typedef struct packed {
        logic signed [NUM_W-1:0] res_num;
        logic signed [DEN_W-1:0] res_den;
        logic [1:0]              cmp_result;
        logic                    zero_gcd_error;
    } rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // capture inputs
        logic mul_a;      // first product pair
        logic mul_b;      // denominator product, form raw pair
        logic gcd_init;   // start Euclid
        logic gcd_step;   // one division bit step
        logic div_init;   // start reduction divides
        logic div_step;
        logic finish;     // build result
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic gcd_done;
        logic div_done;
        logic is_cmp;
        logic is_bad;
    } dp_sts_t;

endpackage

[hdl/rau_datapath.sv]
// Datapath: cross products, Euclidean GCD by serial restoring division, reduction.
`timescale 1ns / 1ps
module rau_datapath (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rau_pkg::req_t           req,
    input  rau_pkg::dp_cmd_t        cmd,
    output rau_pkg::dp_sts_t        sts,
    output rau_pkg::rsp_t           rsp
);
    import rau_pkg::*;

    localparam int PW = 2 * IN_W;          // product width
    localparam int MW = PW + 1;            // magnitude width (sum can grow a bit)
    localparam int CW = $clog2(MW + 1);

    logic [2:0]                 op_reg;
    logic signed [IN_W-1:0]     an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [PW-1:0]       p0_reg, p1_reg;
    logic signed [PW-1:0]       dd_reg;
    logic                       nneg_reg, dneg_reg;
    logic [MW-1:0]              nmag_reg, dmag_reg;
    logic [MW-1:0]              x_reg, y_reg;          // Euclid operands
    logic [MW-1:0]              r_reg, dvd_reg;        // serial divider
    logic [MW-1:0]              q2_reg, r2_reg;        // second divider (den)
    logic [CW-1:0]              cnt_reg;
    logic                       gdiv_reg;              // divider active in Euclid
    logic                       xbig_reg;              // x is the dividend
    rsp_t                       rsp_reg;

    // Product operands chosen per op
    logic signed [IN_W-1:0]     m0a, m0b, m1a, m1b;
    logic signed [PW-1:0]       prod0, prod1;
    always_comb
    begin
        m0a = an_reg; m0b = bd_reg; m1a = bn_reg; m1b = ad_reg;
        case (op_reg)
            OP_MUL:  begin m0a = an_reg; m0b = bn_reg; m1a = ad_reg; m1b = bd_reg; end
            OP_DIV:  begin m0a = an_reg; m0b = bd_reg; m1a = ad_reg; m1b = bn_reg; end
            default: ;
        endcase
    end
    assign prod0 = PW'(m0a * m0b);
    assign prod1 = PW'(m1a * m1b);

    // Raw numerator/denominator and their magnitudes
    logic signed [MW:0] raw_n, raw_d, ext0, ext1, extd;
    assign ext0 = (MW+1)'(p0_reg);
    assign ext1 = (MW+1)'(p1_reg);
    assign extd = (MW+1)'(dd_reg);
    always_comb
    begin
        raw_n = ext0;
        raw_d = ext1;
        case (op_reg)
            OP_ADD:    begin raw_n = ext0 + ext1; raw_d = extd; end
            OP_SUB:    begin raw_n = ext0 - ext1; raw_d = extd; end
            OP_REDUCE: begin
                raw_n = (MW+1)'(an_reg);
                raw_d = (MW+1)'(ad_reg);
            end
            default: ;
        endcase
    end

    // Divider steps: trial is shared by Euclid and the numerator reduction, trial2 reduces the den
    logic [MW:0]   trial, trial2;
    logic [MW-1:0] gdvs;
    assign gdvs   = xbig_reg ? y_reg : x_reg;
    assign trial  = {r_reg, dvd_reg[MW-1]} - {1'b0, gdiv_reg ? gdvs : x_reg};
    assign trial2 = {r2_reg, q2_reg[MW-1]} - {1'b0, x_reg};

    logic [MW-1:0] rem_now;
    assign rem_now = trial[MW] ? {r_reg[MW-2:0], dvd_reg[MW-1]} : trial[MW-1:0];

    // Result beat contents
    rsp_t fin_rsp;
    always_comb
    begin
        fin_rsp = '0;
        if (op_reg == OP_CMP)
        begin
            fin_rsp.cmp_result = (p0_reg > p1_reg) ? CMP_GT :
                                 (p0_reg < p1_reg) ? CMP_LT : CMP_EQ;
        end
        else if (op_reg < OP_CMP)
        begin
            if (x_reg == '0)
                fin_rsp.zero_gcd_error = 1'b1;
            else
            begin
                fin_rsp.res_num = NUM_W'(nneg_reg ? -{1'b0, dvd_reg} : {1'b0, dvd_reg});
                fin_rsp.res_den = DEN_W'(dneg_reg ? -{1'b0, q2_reg} : {1'b0, q2_reg});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            gdiv_reg <= 1'b0;
        end
        else if (cmd.gcd_init || cmd.div_init)
        begin
            cnt_reg  <= '0;
            gdiv_reg <= cmd.gcd_init;
        end
        else if (cmd.gcd_step || cmd.div_step)
        begin
            cnt_reg <= (cnt_reg == CW'(MW-1)) ? '0 : cnt_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= req.req_type;
            an_reg <= req.a_num;
            ad_reg <= req.a_den;
            bn_reg <= req.b_num;
            bd_reg <= req.b_den;
        end
        if (cmd.mul_a)
        begin
            p0_reg <= prod0;
            p1_reg <= prod1;
        end
        if (cmd.mul_b)
        begin
            dd_reg   <= PW'(ad_reg * bd_reg);
        end
        if (cmd.gcd_init)
        begin
            nneg_reg <= raw_n[MW];
            dneg_reg <= raw_d[MW];
            nmag_reg <= raw_n[MW] ? MW'(-raw_n) : raw_n[MW-1:0];
            dmag_reg <= raw_d[MW] ? MW'(-raw_d) : raw_d[MW-1:0];
            x_reg    <= raw_n[MW] ? MW'(-raw_n) : raw_n[MW-1:0];
            y_reg    <= raw_d[MW] ? MW'(-raw_d) : raw_d[MW-1:0];
            xbig_reg <= (raw_n[MW] ? MW'(-raw_n) : raw_n[MW-1:0])
                        > (raw_d[MW] ? MW'(-raw_d) : raw_d[MW-1:0]);
            r_reg    <= '0;
            dvd_reg  <= (raw_n[MW] ? MW'(-raw_n) : raw_n[MW-1:0])
                        > (raw_d[MW] ? MW'(-raw_d) : raw_d[MW-1:0])
                        ? (raw_n[MW] ? MW'(-raw_n) : raw_n[MW-1:0])
                        : (raw_d[MW] ? MW'(-raw_d) : raw_d[MW-1:0]);
        end
        // Euclid: the larger is replaced by its remainder, one bit per cycle
        if (cmd.gcd_step)
        begin
            if (cnt_reg == CW'(MW-1))
            begin
                if (xbig_reg)
                    x_reg <= rem_now;
                else
                    y_reg <= rem_now;
                xbig_reg <= xbig_reg ? (rem_now > y_reg) : (x_reg > rem_now);
                r_reg    <= '0;
                dvd_reg  <= xbig_reg ? ((rem_now > y_reg) ? rem_now : y_reg)
                                     : ((rem_now > x_reg) ? rem_now : x_reg);
            end
            else
            begin
                r_reg   <= rem_now;
                dvd_reg <= {dvd_reg[MW-2:0], 1'b0};
            end
        end
        // Reduction: x holds gcd (x+y), two dividers run side by side
        if (cmd.div_init)
        begin
            x_reg   <= x_reg + y_reg;
            r_reg   <= '0;
            r2_reg  <= '0;
            dvd_reg <= nmag_reg;
            q2_reg  <= dmag_reg;
        end
        if (cmd.div_step)
        begin
            r_reg   <= trial[MW]  ? {r_reg[MW-2:0], dvd_reg[MW-1]}  : trial[MW-1:0];
            dvd_reg <= {dvd_reg[MW-2:0], ~trial[MW]};
            r2_reg  <= trial2[MW] ? {r2_reg[MW-2:0], q2_reg[MW-1]} : trial2[MW-1:0];
            q2_reg  <= {q2_reg[MW-2:0], ~trial2[MW]};
        end
        if (cmd.finish)
        begin
            rsp_reg <= fin_rsp;
        end
    end

    assign sts.gcd_done = (x_reg == '0) || (y_reg == '0);
    assign sts.div_done = (cnt_reg == CW'(MW-1));
    assign sts.is_cmp   = (op_reg >= OP_CMP);
    assign sts.is_bad   = (x_reg == '0) && (y_reg == '0);
    assign rsp          = rsp_reg;

endmodule

[hdl/rau_ctrl.sv]
// Controller: sequences load, products, Euclid loop, reduction and result beat.
`timescale 1ns / 1ps
module rau_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    output logic              done,
    input  rau_pkg::dp_sts_t  sts,
    output rau_pkg::dp_cmd_t  cmd
);
    import rau_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MULA  = 8'b0000_0010,
        S_MULB  = 8'b0000_0100,
        S_GINIT = 8'b0000_1000,
        S_GCD   = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_FIN   = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   gchk_reg, gchk_next;   // first cycle of a Euclid round checks for zero

    always_comb
    begin
        state_next = state_reg;
        gchk_next  = gchk_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
                if (start) state_next = S_MULA;
            end
            S_MULA:
            begin
                cmd.mul_a  = 1'b1;
                state_next = S_MULB;
            end
            S_MULB:
            begin
                cmd.mul_b  = 1'b1;
                state_next = sts.is_cmp ? S_FIN : S_GINIT;
            end
            S_GINIT:
            begin
                cmd.gcd_init = 1'b1;
                gchk_next    = 1'b1;
                state_next   = S_GCD;
            end
            S_GCD:
            begin
                if (gchk_reg && sts.gcd_done)
                begin
                    if (sts.is_bad)
                        state_next = S_FIN;
                    else
                    begin
                        cmd.div_init = 1'b1;
                        state_next   = S_DIV;
                    end
                end
                else
                begin
                    cmd.gcd_step = 1'b1;
                    gchk_next    = sts.div_done;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done) state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            gchk_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            gchk_reg  <= gchk_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_OUT);

endmodule

[hdl/rational_arithmetic_unit.sv]
// Top level of the rational arithmetic unit.
//   channel | signals                 | direction | handshake
//   request | start, busy, req        | in        | start && !busy
//   result  | done, rsp               | out       | done, one cycle, no stall
// Compare and undefined codes skip the Euclid loop and reduction, and a 0/0 pair skips
// reduction; otherwise the bit-serial remainder loop of the Euclid step sets how long
// an item takes.
// Reset returns the controller to idle; busy stays high through the result beat.
// The result beat cannot be stalled; the next start is taken the cycle after it.
`timescale 1ns / 1ps
module rational_arithmetic_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  rau_pkg::req_t  req,
    output logic           done,
    output rau_pkg::rsp_t  rsp
);
    import rau_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    rau_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .sts   (sts),
        .cmd   (cmd)
    );

    rau_datapath u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp)
    );

endmodule

[hdl/rau_checker.sv]
// Port-level checker for the rational arithmetic unit, bound to the top level.
`timescale 1ns / 1ps
module rau_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input rau_pkg::rsp_t rsp
);
    import rau_pkg::*;

    // Accepted beat makes the unit busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not raise busy");

    // Result beat lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // Result only while busy, and unit idles right after
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy ##1 !busy)
        else $error("done outside a busy period");

    // Error beat carries 0/0
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.zero_gcd_error |-> rsp.res_num == '0 && rsp.res_den == '0)
        else $error("error beat with nonzero fraction");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

[verif/tb_rational_arithmetic_unit.sv]
// Testbench for the rational arithmetic unit: random and directed fraction beats, scoreboard check.
`timescale 1ns / 1ps
module tb_rational_arithmetic_unit;
    import rau_pkg::*;

    localparam int HANG_LIMIT = 40000;
    localparam int N_RANDOM = 1130;

    // expected results kept in beat order, predicted from each accepted request
    class fraction_scoreboard;
        rsp_t pending_rsp[$];
        int   errors;

        function new();
            errors = 0;
        endfunction

        function rsp_t predict_fraction(req_t r);
            rsp_t       p;
            longint     an, ad, bn, bd, n, d, lhs, rhs;
            longint unsigned x, y, g;
            p = '0;
            an = r.a_num;
            ad = r.a_den;
            bn = r.b_num;
            bd = r.b_den;
            n = 0;
            d = 0;
            case (r.req_type)
                OP_ADD:
                begin
                    n = an * bd + bn * ad;
                    d = ad * bd;
                end
                OP_SUB:
                begin
                    n = an * bd - bn * ad;
                    d = ad * bd;
                end
                OP_MUL:
                begin
                    n = an * bn;
                    d = ad * bd;
                end
                OP_DIV:
                begin
                    n = an * bd;
                    d = ad * bn;
                end
                OP_REDUCE:
                begin
                    n = an;
                    d = ad;
                end
                OP_CMP:
                begin
                    lhs = an * bd;
                    rhs = ad * bn;
                    p.cmp_result = (lhs > rhs) ? CMP_GT : ((lhs < rhs) ? CMP_LT : CMP_EQ);
                    return p;
                end
                default: return p;
            endcase
            // Euclid on magnitudes; both zero leaves a zero divisor
            x = (n < 0) ? -n : n;
            y = (d < 0) ? -d : d;
            while (x != 0 && y != 0)
            begin
                if (x > y)
                    x = x % y;
                else
                    y = y % x;
            end
            g = x + y;
            if (g == 0)
            begin
                p.zero_gcd_error = 1'b1;
                return p;
            end
            n = n / longint'(g);
            d = d / longint'(g);
            p.res_num = n[NUM_W-1:0];
            p.res_den = d[DEN_W-1:0];
            return p;
        endfunction

        function void note_request(req_t r);
            pending_rsp.push_back(predict_fraction(r));
        endfunction

        function void check_result(rsp_t got);
            rsp_t exp_rsp;
            if (pending_rsp.size() == 0)
            begin
                $error("result beat with nothing expected: %h", got);
                errors++;
                return;
            end
            exp_rsp = pending_rsp.pop_front();
            if (got.res_num !== exp_rsp.res_num)
            begin
                $error("res_num expected %0d got %0d", exp_rsp.res_num, got.res_num);
                errors++;
            end
            if (got.res_den !== exp_rsp.res_den)
            begin
                $error("res_den expected %0d got %0d", exp_rsp.res_den, got.res_den);
                errors++;
            end
            if (got.cmp_result !== exp_rsp.cmp_result)
            begin
                $error("cmp_result expected %0d got %0d", exp_rsp.cmp_result, got.cmp_result);
                errors++;
            end
            if (got.zero_gcd_error !== exp_rsp.zero_gcd_error)
            begin
                $error("zero_gcd_error expected %0d got %0d",
                       exp_rsp.zero_gcd_error, got.zero_gcd_error);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    rsp_t rsp;

    fraction_scoreboard sb;
    bit no_gaps;
    int stall_count;

    rational_arithmetic_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // monitor: accepted request beats and result beats, plus hang watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_request(req);
            if (done)
                sb.check_result(rsp);
            if ((start && !busy) || done)
                stall_count = 0;
            else
                stall_count++;
            if (stall_count >= HANG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // operand mix: extremes, small values, zero, full range
    function automatic logic [15:0] pick_operand();
        case ($urandom_range(9))
            0: return 16'sh0000;
            1: return 16'sh8000;
            2: return 16'sh7fff;
            3: return $urandom_range(1) ? 16'sh0001 : 16'shffff;
            4, 5: return 16'($signed($urandom_range(40)) - 20);
            default: return 16'($urandom);
        endcase
    endfunction

    // one request beat; holds start until the unit takes it
    task automatic send_request(input req_t r);
        while (!no_gaps && $urandom_range(99) < 26)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic send_fields(input logic [2:0] op, input logic [15:0] an,
                               input logic [15:0] ad, input logic [15:0] bn,
                               input logic [15:0] bd);
        req_t r;
        r.req_type = op;
        r.a_num = an;
        r.a_den = ad;
        r.b_num = bn;
        r.b_den = bd;
        send_request(r);
    endtask

    initial
    begin
        req_t r;
        sb = new();
        stall_count = 0;
        no_gaps = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: every operation, extremes, zero-divisor and half-zero cases
        for (int op = OP_ADD; op <= OP_CMP; op++)
            send_fields(op[2:0], 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000);
        send_fields(OP_MUL, 16'sh0000, 16'sh0003, 16'sh0005, 16'sh0000);
        send_fields(OP_REDUCE, 16'sh0000, 16'sh0000, 16'sh0001, 16'sh0001);
        send_fields(OP_REDUCE, 16'sh0000, 16'shfff9, 16'sh0000, 16'sh0000);
        send_fields(OP_REDUCE, 16'shfffa, 16'sh0000, 16'sh0000, 16'sh0000);
        send_fields(OP_REDUCE, 16'sh0006, 16'shfff7, 16'sh0000, 16'sh0000);
        send_fields(OP_ADD, 16'sh0001, 16'sh0002, 16'shffff, 16'sh0002);
        send_fields(OP_SUB, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff);
        send_fields(OP_DIV, 16'sh0003, 16'sh0004, 16'sh0000, 16'sh0007);
        send_fields(OP_CMP, 16'sh0001, 16'sh0002, 16'sh0002, 16'sh0004);
        send_fields(OP_CMP, 16'shffff, 16'sh0002, 16'sh0001, 16'sh0002);
        send_fields(3'd6, 16'sh1234, 16'sh0001, 16'sh0001, 16'sh0001);
        send_fields(3'd7, 16'shffff, 16'shffff, 16'shffff, 16'shffff);
        send_fields(OP_MUL, 16'shffff, 16'shffff, 16'shffff, 16'shffff);
        send_fields(OP_ADD, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);

        // random: mostly defined codes, a few undefined ones
        for (int i = 0; i < N_RANDOM; i++)
        begin
            no_gaps = (i >= 400 && i < 600);
            r.req_type = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6))
                                                  : 3'($urandom_range(OP_CMP));
            r.a_num = pick_operand();
            r.a_den = pick_operand();
            r.b_num = pick_operand();
            r.b_den = pick_operand();
            send_request(r);
        end
        start <= 1'b0;

        while (sb.pending_rsp.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        if (sb.pending_rsp.size() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending_rsp.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

[rational_arithmetic_unit.f]
hdl/rau_pkg.sv
hdl/rau_datapath.sv
hdl/rau_ctrl.sv
hdl/rational_arithmetic_unit.sv
hdl/rau_checker.sv
verif/tb_rational_arithmetic_unit.sv
